// File: src/esc_pkg.sv
package esc_pkg;

  // Reading kinds carried on req_type and echoed on kind.
  localparam logic [1:0] KIND_TEMP  = 2'd0;
  localparam logic [1:0] KIND_PRESS = 2'd1;
  localparam logic [1:0] KIND_HUM   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_A   = 3'd4;
  localparam logic [2:0] REG_HUM_CAL_B   = 3'd5;

  // Micro-operations of the shared datapath.
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_ASR   = 3'd2;
  localparam logic [2:0] OP_ASR32 = 3'd3;
  localparam logic [2:0] OP_MUL   = 3'd4;
  localparam logic [2:0] OP_DIV   = 3'd5;
  localparam logic [2:0] OP_CHKZ  = 3'd6;

  // Entry points of the three micro-programs.
  localparam logic [6:0] PC_TEMP  = 7'd0;
  localparam logic [6:0] PC_PRESS = 7'd16;
  localparam logic [6:0] PC_HUM   = 7'd48;

  // Humidity upper clamp, 100 %rH before the final shift.
  localparam logic [31:0] HUM_MAX_RAW = 32'd419430400;

  // One decoded micro-instruction.
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  dst;
    logic [5:0]  sh;
    logic        last;
  } uop_t;

endpackage

// File: src/env_sensor_compensation.sv
// Channel   | Signals                                  | Direction
// ----------+------------------------------------------+----------
// request   | req_valid, req_stall, req_type, raw_value | in
// result    | rsp_valid, rsp_stall, kind, value,        | out
//           | div_zero, clamped                        |
// config    | cfg_we, cfg_index, cfg_data              | in
//
// Each 64x64 product is built from partial products on the one 32x32
// multiplier, and the pressure division runs on the radix-2 divider; a
// pressure request with a zero divisor ends at the divisor check instead.
// req_stall is high while a request is worked on, so the next request is taken
// in the cycle after the result is loaded at the earliest.
// Reset clears the calibration registers, the stored fine temperature and
// all control state. A request of kind 3 is taken and gives no result.
// A finished result waits in the output register under rsp_stall while the
// next request is already being taken; that request holds its last step until
// the output register is free.
module env_sensor_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic [19:0]        raw_value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         kind,
  output logic signed [31:0] value,
  output logic               div_zero,
  output logic               clamped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  // Calibration registers and stored state.
  logic [47:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  logic [31:0] hum_cal_a, hum_cal_b;
  logic [31:0] fine_temp;

  // Sequencer and working registers.
  logic        busy;
  logic [6:0]  pc;
  logic [1:0]  cur_kind;
  logic [19:0] raw;
  logic [63:0] r0, r1, r2, r3;

  // Multiplier and divider state.
  logic [1:0]  mcnt;
  logic [63:0] prod, acc;
  logic [6:0]  dcnt;
  logic [63:0] rem, quo, dmag;
  logic        dneg;

  // Sign- and zero-extended calibration fields.
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6, ft64, adc;

  assign t1 = {48'd0, temp_cal[15:0]};
  assign t2 = {{48{temp_cal[31]}}, temp_cal[31:16]};
  assign t3 = {{48{temp_cal[47]}}, temp_cal[47:32]};
  assign p1 = {48'd0, press_cal_a[15:0]};
  assign p2 = {{48{press_cal_a[31]}}, press_cal_a[31:16]};
  assign p3 = {{48{press_cal_a[47]}}, press_cal_a[47:32]};
  assign p4 = {{48{press_cal_b[15]}}, press_cal_b[15:0]};
  assign p5 = {{48{press_cal_b[31]}}, press_cal_b[31:16]};
  assign p6 = {{48{press_cal_b[47]}}, press_cal_b[47:32]};
  assign p7 = {{48{press_cal_c[15]}}, press_cal_c[15:0]};
  assign p8 = {{48{press_cal_c[31]}}, press_cal_c[31:16]};
  assign p9 = {{48{press_cal_c[47]}}, press_cal_c[47:32]};
  assign h1 = {56'd0, hum_cal_a[7:0]};
  assign h2 = {{48{hum_cal_a[23]}}, hum_cal_a[23:8]};
  assign h3 = {56'd0, hum_cal_a[31:24]};
  assign h4 = {{52{hum_cal_b[11]}}, hum_cal_b[11:0]};
  assign h5 = {{52{hum_cal_b[23]}}, hum_cal_b[23:12]};
  assign h6 = {{56{hum_cal_b[31]}}, hum_cal_b[31:24]};
  assign ft64 = {{32{fine_temp[31]}}, fine_temp};
  assign adc  = {44'd0, raw};

  // Micro-program: one operation, its operands and destination per step.
  esc_pkg::uop_t uop;
  logic [63:0]   opa, opb;

  always_comb begin
    uop = '{op: esc_pkg::OP_ADD, dst: 2'd0, sh: 6'd0, last: 1'b0};
    opa = 64'd0;
    opb = 64'd0;
    unique case (pc)
      // Temperature.
      7'd0: begin
        uop.op = esc_pkg::OP_SUB; opa = adc >> 3; opb = t1 << 1;
      end
      7'd1: begin uop.op = esc_pkg::OP_MUL; opa = r0; opb = t2; end
      7'd2: begin uop.op = esc_pkg::OP_ASR; opa = r0; uop.sh = 6'd11; end
      7'd3: begin
        uop.op = esc_pkg::OP_SUB; uop.dst = 2'd1; opa = adc >> 4; opb = t1;
      end
      7'd4: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd1; opa = r1; opb = r1; end
      7'd5: begin uop.op = esc_pkg::OP_ASR; uop.dst = 2'd1; opa = r1; uop.sh = 6'd12; end
      7'd6: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd1; opa = r1; opb = t3; end
      7'd7: begin uop.op = esc_pkg::OP_ASR; uop.dst = 2'd1; opa = r1; uop.sh = 6'd14; end
      7'd8: begin uop.op = esc_pkg::OP_ADD; opa = r0; opb = r1; end
      7'd9: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd1; opa = r0 << 2; opb = r0; end
      7'd10: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd1; opa = r1; opb = 64'd128; end
      7'd11: begin
        uop.op = esc_pkg::OP_ASR; uop.dst = 2'd1; opa = r1; uop.sh = 6'd8;
        uop.last = 1'b1;
      end
      // Pressure.
      7'd16: begin uop.op = esc_pkg::OP_SUB; opa = ft64; opb = 64'd128000; end
      7'd17: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd1; opa = r0; opb = r0; end
      7'd18: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd1; opa = r1; opb = p6; end
      7'd19: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r0; opb = p5; end
      7'd20: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd1; opa = r1; opb = r2 << 17; end
      7'd21: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd1; opa = r1; opb = p4 << 35; end
      7'd22: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r0; opb = r0; end
      7'd23: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r2; opb = p3; end
      7'd24: begin uop.op = esc_pkg::OP_ASR; uop.dst = 2'd2; opa = r2; uop.sh = 6'd8; end
      7'd25: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd3; opa = r0; opb = p2; end
      7'd26: begin uop.op = esc_pkg::OP_ADD; opa = r2; opb = r3 << 12; end
      7'd27: begin uop.op = esc_pkg::OP_ADD; opa = r0; opb = 64'd1 << 47; end
      7'd28: begin uop.op = esc_pkg::OP_MUL; opa = r0; opb = p1; end
      7'd29: begin uop.op = esc_pkg::OP_ASR; opa = r0; uop.sh = 6'd33; end
      7'd30: begin uop.op = esc_pkg::OP_CHKZ; opa = r0; end
      7'd31: begin
        uop.op = esc_pkg::OP_SUB; uop.dst = 2'd2; opa = 64'd1048576; opb = adc;
      end
      7'd32: begin uop.op = esc_pkg::OP_SUB; uop.dst = 2'd2; opa = r2 << 31; opb = r1; end
      7'd33: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r2; opb = 64'd3125; end
      7'd34: begin uop.op = esc_pkg::OP_DIV; uop.dst = 2'd2; opa = r2; opb = r0; end
      7'd35: begin uop.op = esc_pkg::OP_ASR; uop.dst = 2'd3; opa = r2; uop.sh = 6'd13; end
      7'd36: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd3; opa = r3; opb = r3; end
      7'd37: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd3; opa = r3; opb = p9; end
      7'd38: begin uop.op = esc_pkg::OP_ASR; uop.dst = 2'd3; opa = r3; uop.sh = 6'd25; end
      7'd39: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd1; opa = r2; opb = p8; end
      7'd40: begin uop.op = esc_pkg::OP_ASR; uop.dst = 2'd1; opa = r1; uop.sh = 6'd19; end
      7'd41: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd2; opa = r2; opb = r3; end
      7'd42: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd2; opa = r2; opb = r1; end
      7'd43: begin uop.op = esc_pkg::OP_ASR; uop.dst = 2'd2; opa = r2; uop.sh = 6'd8; end
      7'd44: begin
        uop.op = esc_pkg::OP_ADD; uop.dst = 2'd2; opa = r2; opb = p7 << 4;
        uop.last = 1'b1;
      end
      // Humidity, 32-bit wrapping arithmetic on the low word.
      7'd48: begin uop.op = esc_pkg::OP_SUB; opa = ft64; opb = 64'd76800; end
      7'd49: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd1; opa = r0; opb = h5; end
      7'd50: begin
        uop.op = esc_pkg::OP_SUB; uop.dst = 2'd1; opa = {36'd0, raw[15:0], 12'd0} << 2;
        opb = r1;
      end
      7'd51: begin uop.op = esc_pkg::OP_SUB; uop.dst = 2'd1; opa = r1; opb = h4 << 20; end
      7'd52: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd1; opa = r1; opb = 64'd16384; end
      7'd53: begin uop.op = esc_pkg::OP_ASR32; uop.dst = 2'd1; opa = r1; uop.sh = 6'd15; end
      7'd54: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r0; opb = h6; end
      7'd55: begin uop.op = esc_pkg::OP_ASR32; uop.dst = 2'd2; opa = r2; uop.sh = 6'd10; end
      7'd56: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd3; opa = r0; opb = h3; end
      7'd57: begin uop.op = esc_pkg::OP_ASR32; uop.dst = 2'd3; opa = r3; uop.sh = 6'd11; end
      7'd58: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd3; opa = r3; opb = 64'd32768; end
      7'd59: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r2; opb = r3; end
      7'd60: begin uop.op = esc_pkg::OP_ASR32; uop.dst = 2'd2; opa = r2; uop.sh = 6'd10; end
      7'd61: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd2; opa = r2; opb = 64'd2097152; end
      7'd62: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r2; opb = h2; end
      7'd63: begin uop.op = esc_pkg::OP_ADD; uop.dst = 2'd2; opa = r2; opb = 64'd8192; end
      7'd64: begin uop.op = esc_pkg::OP_ASR32; uop.dst = 2'd2; opa = r2; uop.sh = 6'd14; end
      7'd65: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd1; opa = r1; opb = r2; end
      7'd66: begin uop.op = esc_pkg::OP_ASR32; uop.dst = 2'd2; opa = r1; uop.sh = 6'd15; end
      7'd67: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r2; opb = r2; end
      7'd68: begin uop.op = esc_pkg::OP_ASR32; uop.dst = 2'd2; opa = r2; uop.sh = 6'd7; end
      7'd69: begin uop.op = esc_pkg::OP_MUL; uop.dst = 2'd2; opa = r2; opb = h1; end
      7'd70: begin uop.op = esc_pkg::OP_ASR32; uop.dst = 2'd2; opa = r2; uop.sh = 6'd4; end
      7'd71: begin
        uop.op = esc_pkg::OP_SUB; uop.dst = 2'd1; opa = r1; opb = r2;
        uop.last = 1'b1;
      end
      default: uop.last = 1'b1;
    endcase
  end

  // Combinational part of the shared datapath: add, subtract and shifts.
  logic [63:0] alu_res;

  always_comb begin
    unique case (uop.op)
      esc_pkg::OP_ADD:   alu_res = opa + opb;
      esc_pkg::OP_SUB:   alu_res = opa - opb;
      esc_pkg::OP_ASR:   alu_res = 64'($signed(opa) >>> uop.sh);
      esc_pkg::OP_ASR32: alu_res = 64'($signed({{32{opa[31]}}, opa[31:0]}) >>> uop.sh);
      default:           alu_res = opa;
    endcase
  end

  // The one 32x32 multiplier; partial products are picked by mcnt.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  assign mul_a = (mcnt == 2'd2) ? opa[63:32] : opa[31:0];
  assign mul_b = (mcnt == 2'd1) ? opb[63:32] : opb[31:0];
  assign mul_p = mul_a * mul_b;

  // Divider trial subtract.
  logic [64:0] div_t;
  logic        div_ge;

  assign div_t  = {rem, quo[63]};
  assign div_ge = div_t >= {1'b0, dmag};

  // Humidity clamp on the final low word.
  logic [31:0] hum_x;
  logic [31:0] hum_c;
  logic        hum_cl;

  always_comb begin
    hum_x = alu_res[31:0];
    priority if (hum_x[31]) begin
      hum_c  = 32'd0;
      hum_cl = 1'b1;
    end else if (hum_x > esc_pkg::HUM_MAX_RAW) begin
      hum_c  = esc_pkg::HUM_MAX_RAW;
      hum_cl = 1'b1;
    end else begin
      hum_c  = hum_x;
      hum_cl = 1'b0;
    end
  end

  logic fin_ok;
  logic res_load;
  logic wr_en;
  logic [63:0] wr_data;

  assign fin_ok    = !rsp_valid || !rsp_stall;
  assign req_stall = busy;

  // The result register is loaded by a zero divisor or by the last step.
  assign res_load = busy && fin_ok &&
    ((uop.op == esc_pkg::OP_CHKZ && r0 == 64'd0) ||
     (uop.op != esc_pkg::OP_MUL && uop.op != esc_pkg::OP_DIV &&
      uop.op != esc_pkg::OP_CHKZ && uop.last));

  // Destination write of the working registers.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = alu_res;
    if (busy) begin
      unique case (uop.op)
        esc_pkg::OP_MUL: begin
          wr_en   = (mcnt == 2'd3);
          wr_data = acc + {prod[31:0], 32'd0};
        end
        esc_pkg::OP_DIV: begin
          wr_en   = (dcnt == 7'd65);
          wr_data = dneg ? (64'd0 - quo) : quo;
        end
        esc_pkg::OP_CHKZ: wr_en = 1'b0;
        default: wr_en = !uop.last || fin_ok;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (uop.dst)
        2'd0: r0 <= wr_data;
        2'd1: r1 <= wr_data;
        2'd2: r2 <= wr_data;
        default: r3 <= wr_data;
      endcase
    end
  end

  // Multiply and divide working registers.
  always_ff @(posedge clk) begin
    if (busy && uop.op == esc_pkg::OP_MUL) begin
      prod <= mul_p;
      if (mcnt == 2'd1) begin
        acc <= prod;
      end else if (mcnt == 2'd2) begin
        acc <= acc + {prod[31:0], 32'd0};
      end
    end
    if (busy && uop.op == esc_pkg::OP_DIV) begin
      if (dcnt == 7'd0) begin
        rem  <= 64'd0;
        quo  <= opa[63] ? (64'd0 - opa) : opa;
        dmag <= opb[63] ? (64'd0 - opb) : opb;
        dneg <= opa[63] ^ opb[63];
      end else if (dcnt <= 7'd64) begin
        rem <= div_ge ? 64'(div_t - {1'b0, dmag}) : div_t[63:0];
        quo <= {quo[62:0], div_ge};
      end
    end
  end

  // Sequencer, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pc          <= esc_pkg::PC_TEMP;
      mcnt        <= 2'd0;
      dcnt        <= 7'd0;
      rsp_valid   <= 1'b0;
      fine_temp   <= 32'd0;
      temp_cal    <= 48'd0;
      press_cal_a <= 48'd0;
      press_cal_b <= 48'd0;
      press_cal_c <= 48'd0;
      hum_cal_a   <= 32'd0;
      hum_cal_b   <= 32'd0;
    end else begin
      rsp_valid <= res_load || (rsp_valid && rsp_stall);
      if (cfg_we) begin
        unique case (cfg_index)
          esc_pkg::REG_TEMP_CAL:    temp_cal    <= cfg_data;
          esc_pkg::REG_PRESS_CAL_A: press_cal_a <= cfg_data;
          esc_pkg::REG_PRESS_CAL_B: press_cal_b <= cfg_data;
          esc_pkg::REG_PRESS_CAL_C: press_cal_c <= cfg_data;
          esc_pkg::REG_HUM_CAL_A:   hum_cal_a   <= cfg_data[31:0];
          esc_pkg::REG_HUM_CAL_B:   hum_cal_b   <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (!busy) begin
        if (req_valid) begin
          cur_kind <= req_type;
          raw      <= raw_value;
          unique case (req_type)
            esc_pkg::KIND_TEMP:  begin busy <= 1'b1; pc <= esc_pkg::PC_TEMP;  end
            esc_pkg::KIND_PRESS: begin busy <= 1'b1; pc <= esc_pkg::PC_PRESS; end
            esc_pkg::KIND_HUM:   begin busy <= 1'b1; pc <= esc_pkg::PC_HUM;   end
            default: ;
          endcase
        end
      end else begin
        unique case (uop.op)
          esc_pkg::OP_MUL: begin
            mcnt <= mcnt + 2'd1;
            if (mcnt == 2'd3) begin
              pc <= pc + 7'd1;
            end
          end
          esc_pkg::OP_DIV: begin
            if (dcnt == 7'd65) begin
              dcnt <= 7'd0;
              pc   <= pc + 7'd1;
            end else begin
              dcnt <= dcnt + 7'd1;
            end
          end
          esc_pkg::OP_CHKZ: begin
            if (r0 != 64'd0) begin
              pc <= pc + 7'd1;
            end else if (fin_ok) begin
              busy      <= 1'b0;
              kind      <= cur_kind;
              value     <= 32'sd0;
              div_zero  <= 1'b1;
              clamped   <= 1'b0;
            end
          end
          default: begin
            if (!uop.last) begin
              pc <= pc + 7'd1;
            end else if (fin_ok) begin
              busy      <= 1'b0;
              kind      <= cur_kind;
              div_zero  <= 1'b0;
              clamped   <= (cur_kind == esc_pkg::KIND_HUM) && hum_cl;
              value     <= (cur_kind == esc_pkg::KIND_HUM) ?
                           $signed({12'd0, hum_c[31:12]}) : $signed(alu_res[31:0]);
              if (cur_kind == esc_pkg::KIND_TEMP) begin
                fine_temp <= r0[31:0];
              end
            end
          end
        endcase
      end
    end
  end

  // Only pressure results may flag a zero divisor.
  a_dz_press: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && div_zero |-> kind == esc_pkg::KIND_PRESS)
    else $error("div_zero on a non-pressure result");

  // Only humidity results may be clamped, and then to 0 or 100 percent.
  a_cl_hum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && clamped |-> kind == esc_pkg::KIND_HUM &&
      (value == 32'sd0 || value == 32'sd102400))
    else $error("clamp flag inconsistent with result");

  // The multi-cycle units are at rest whenever the sequencer is idle.
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> mcnt == 2'd0 && dcnt == 7'd0)
    else $error("arithmetic unit active while idle");

  // A new result is only loaded once the previous one has left.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(value))
    else $error("pending result overwritten");

endmodule
